// ===== rtl/core/tacr_pkg.sv =====
package tacr_pkg;

  // Default map geometry and fixed-point format.
  localparam int unsigned MAP_WIDTH_DEF  = 256;
  localparam int unsigned MAP_HEIGHT_DEF = 128;
  localparam int unsigned FRAC_BITS_DEF  = 10;

  // Fixed field widths of the transaction payload.
  localparam int unsigned POS_W    = 21;
  localparam int unsigned HW_W     = 12;
  localparam int unsigned HT_W     = 13;
  localparam int unsigned TX_W     = 8;
  localparam int unsigned TY_W     = 7;
  localparam int unsigned WW_W     = 9;
  localparam int unsigned WH_W     = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Box edges need one bit more than a position; snap results need two more than that.
  localparam int unsigned SUM_W  = POS_W + 1;
  localparam int unsigned CALC_W = SUM_W + 2;

  localparam logic signed [CALC_W-1:0] POS_MAX_C = CALC_W'((64'd1 << (POS_W - 1)) - 64'd1);
  localparam logic signed [CALC_W-1:0] POS_MIN_C = -POS_MAX_C - CALC_W'(1);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TEST  = 2'd1,
    OP_RES_X = 2'd2,
    OP_RES_Y = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORLD_WIDTH  = 1'b0,
    CFG_WORLD_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_WRITE,
    ST_RESOLVE
  } state_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic start;
    logic scan;
    logic write;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic hit;
    logic done;
    logic out_free;
  } dp_status_t;

  function automatic logic [POS_W-1:0] sat_pos(logic signed [CALC_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v > POS_MAX_C) begin
      r = POS_MAX_C[POS_W-1:0];
    end else if (v < POS_MIN_C) begin
      r = POS_MIN_C[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/tacr_ctrl.sv =====
module tacr_ctrl import tacr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  op_e        op_i,
  output logic       in_ready_o,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (op_i == OP_WRITE) ? ST_WRITE : ST_START;
        end
      end
      ST_START: state_d = ST_SCAN;
      ST_SCAN: begin
        if (status_i.hit || status_i.done) state_d = ST_RESOLVE;
      end
      ST_WRITE: state_d = ST_RESOLVE;
      ST_RESOLVE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_START: cmd_o.start = 1'b1;
      ST_SCAN:  cmd_o.scan = 1'b1;
      ST_WRITE: cmd_o.write = 1'b1;
      ST_RESOLVE: cmd_o.finish = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== rtl/core/tacr_dp.sv =====
module tacr_dp import tacr_pkg::*; #(
  parameter int unsigned MAP_WIDTH  = MAP_WIDTH_DEF,
  parameter int unsigned MAP_HEIGHT = MAP_HEIGHT_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [WW_W-1:0]         cfg_wdata_i,
  input  logic [1:0]              op_i,
  input  logic [TX_W-1:0]         tile_x_i,
  input  logic [TY_W-1:0]         tile_y_i,
  input  logic                    tile_solid_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] vel_x_i,
  input  logic signed [POS_W-1:0] vel_y_i,
  input  logic [HW_W-1:0]         half_width_i,
  input  logic [HT_W-1:0]         box_height_i,
  input  logic                    ground_in_i,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic                    collided_o,
  output logic signed [POS_W-1:0] new_pos_x_o,
  output logic signed [POS_W-1:0] new_pos_y_o,
  output logic signed [POS_W-1:0] new_vel_x_o,
  output logic signed [POS_W-1:0] new_vel_y_o,
  output logic                    on_ground_o
);

  localparam int unsigned ColW     = $clog2(MAP_WIDTH);
  localparam int unsigned RowW     = $clog2(MAP_HEIGHT);
  localparam int unsigned AddrW    = RowW + ColW;
  localparam int unsigned MemDepth = MAP_HEIGHT * (2 ** ColW);

  localparam logic [SUM_W-1:0] FloorMask = ~SUM_W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic [SUM_W-1:0] HalfTile  = SUM_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [CALC_W-1:0] OneTile = CALC_W'(64'd1 << FRAC_BITS);
  localparam logic signed [CALC_W-1:0] OneLsb  = CALC_W'(1);

  // Configuration registers.
  logic [WW_W-1:0] ww_q;
  logic [WH_W-1:0] wh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ww_q <= WW_W'(256);
      wh_q <= WH_W'(128);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WORLD_WIDTH:  ww_q <= cfg_wdata_i;
        CFG_WORLD_HEIGHT: wh_q <= cfg_wdata_i[WH_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured transaction and precomputed box edges.
  op_e                    op_q;
  logic [TX_W-1:0]        tile_x_q;
  logic [TY_W-1:0]        tile_y_q;
  logic                   tile_solid_q;
  logic signed [POS_W-1:0] px_q, py_q, vx_q, vy_q;
  logic [HW_W-1:0]        hw_q;
  logic [HT_W-1:0]        ht_q;
  logic                   gin_q;
  logic signed [SUM_W-1:0] xlo_q, xhi_q, ylo_q;
  logic [SUM_W-1:0]       rnd_q;

  logic signed [SUM_W-1:0] px_ext, py_ext, px_mag;
  logic signed [SUM_W-1:0] hw_ext, ht_ext;

  assign px_ext = SUM_W'(pos_x_i);
  assign py_ext = SUM_W'(pos_y_i);
  assign hw_ext = $signed(SUM_W'(half_width_i));
  assign ht_ext = $signed(SUM_W'(box_height_i));
  assign px_mag = pos_x_i[POS_W-1] ? -px_ext : px_ext;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q         <= op_e'(op_i);
      tile_x_q     <= tile_x_i;
      tile_y_q     <= tile_y_i;
      tile_solid_q <= tile_solid_i;
      px_q         <= pos_x_i;
      py_q         <= pos_y_i;
      vx_q         <= vel_x_i;
      vy_q         <= vel_y_i;
      hw_q         <= half_width_i;
      ht_q         <= box_height_i;
      gin_q        <= ground_in_i;
      xlo_q        <= px_ext - hw_ext;
      xhi_q        <= px_ext + hw_ext;
      ylo_q        <= py_ext - ht_ext;
      rnd_q        <= (px_mag + HalfTile) & FloorMask;
    end
  end

  // Tile span of the box; an arithmetic shift is a floor.
  logic signed [SUM_W-1:0] x0, x1, y0, y1;
  assign x0 = xlo_q >>> FRAC_BITS;
  assign x1 = xhi_q >>> FRAC_BITS;
  assign y0 = ylo_q >>> FRAC_BITS;
  assign y1 = $signed(SUM_W'(py_q)) >>> FRAC_BITS;

  // Scan walker: issues one tile per cycle and checks it in the cycle after.
  logic signed [SUM_W-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic                    iss_q, iss_d;
  logic                    pend_valid_q, pend_solid_q, pend_mem_q, pend_last_q;
  logic                    hit_q;
  logic                    col_out, row_out, forced_solid, mem_tile, is_last;
  logic                    rd_q;
  logic                    pend_hit;

  assign col_out = cur_x_q[SUM_W-1]
                || (cur_x_q >= $signed(SUM_W'(ww_q)))
                || (cur_x_q >= $signed(SUM_W'(MAP_WIDTH)));
  assign row_out = !cur_y_q[SUM_W-1]
                && ((cur_y_q >= $signed(SUM_W'(wh_q)))
                 || (cur_y_q >= $signed(SUM_W'(MAP_HEIGHT))));
  assign forced_solid = col_out || row_out;
  // Rows above the world are open air, except in columns outside it.
  assign mem_tile = !forced_solid && !cur_y_q[SUM_W-1];
  assign is_last  = (cur_x_q == x1) && (cur_y_q == y1);
  assign pend_hit = pend_valid_q && (pend_solid_q || (pend_mem_q && rd_q));

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    iss_d   = iss_q;
    if (cmd_i.start) begin
      cur_x_d = x0;
      cur_y_d = y0;
      iss_d   = 1'b1;
    end else if (cmd_i.scan && iss_q) begin
      if (cur_x_q == x1) begin
        cur_x_d = x0;
        cur_y_d = cur_y_q + SUM_W'(1);
      end else begin
        cur_x_d = cur_x_q + SUM_W'(1);
      end
      if (is_last) iss_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      hit_q        <= 1'b0;
    end else begin
      iss_q        <= iss_d;
      pend_valid_q <= cmd_i.scan && iss_q;
      if (cmd_i.load) begin
        hit_q <= 1'b0;
      end else if (cmd_i.scan && pend_hit) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q      <= cur_x_d;
    cur_y_q      <= cur_y_d;
    pend_solid_q <= forced_solid;
    pend_mem_q   <= mem_tile;
    pend_last_q  <= is_last;
  end

  // Tile map memory and its clearing sweep after reset.
  logic             map_q [MemDepth];
  logic [AddrW-1:0] clr_addr_q, wr_addr, rd_addr;
  logic             clr_done_q;
  logic [31:0]      tx_ext, ty_ext;
  logic             wr_ok;

  assign tx_ext  = 32'(tile_x_q);
  assign ty_ext  = 32'(tile_y_q);
  assign wr_ok   = (tx_ext < 32'(MAP_WIDTH)) && (ty_ext < 32'(MAP_HEIGHT));
  assign wr_addr = {ty_ext[RowW-1:0], tx_ext[ColW-1:0]};
  assign rd_addr = {cur_y_q[RowW-1:0], cur_x_q[ColW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_done_q <= 1'b0;
    end else if (cmd_i.clear) begin
      if (clr_addr_q == AddrW'(MemDepth - 1)) begin
        clr_done_q <= 1'b1;
      end else begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      map_q[clr_addr_q] <= 1'b0;
    end else if (cmd_i.write && wr_ok) begin
      map_q[wr_addr] <= tile_solid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= map_q[rd_addr];
  end

  // Snap arithmetic.
  logic signed [CALC_W-1:0] xhi_fl, xlo_fl, ylo_fl, py_fl, hw_c, ht_c, rnd_c;
  logic signed [CALC_W-1:0] nx_right, nx_left, nx_round, ny_down, ny_up;
  logic                     vx_pos, vx_neg, vy_neg;

  assign xhi_fl = CALC_W'($signed(xhi_q & FloorMask));
  assign xlo_fl = CALC_W'($signed(xlo_q & FloorMask));
  assign ylo_fl = CALC_W'($signed(ylo_q & FloorMask));
  assign py_fl  = CALC_W'($signed(SUM_W'(py_q) & FloorMask));
  assign hw_c   = $signed(CALC_W'(hw_q));
  assign ht_c   = $signed(CALC_W'(ht_q));
  assign rnd_c  = $signed(CALC_W'(rnd_q));

  assign nx_right = xhi_fl - hw_c - OneLsb;
  assign nx_left  = xlo_fl + OneTile + hw_c + OneLsb;
  assign nx_round = px_q[POS_W-1] ? -rnd_c : rnd_c;
  assign ny_down  = py_fl - OneLsb;
  assign ny_up    = ylo_fl + OneTile + ht_c + OneLsb;

  assign vx_neg = vx_q[POS_W-1];
  assign vx_pos = !vx_q[POS_W-1] && (vx_q != '0);
  assign vy_neg = vy_q[POS_W-1];

  logic signed [POS_W-1:0] nx, ny, nvx, nvy;
  logic                    gnd;

  always_comb begin
    nx  = px_q;
    ny  = py_q;
    nvx = vx_q;
    nvy = vy_q;
    gnd = gin_q;
    case (op_q)
      OP_RES_X: begin
        if (hit_q) begin
          if (vx_pos) begin
            nx = sat_pos(nx_right);
          end else if (vx_neg) begin
            nx = sat_pos(nx_left);
          end else begin
            nx = sat_pos(nx_round);
          end
          nvx = '0;
        end
      end
      OP_RES_Y: begin
        if (!hit_q) begin
          gnd = 1'b0;
        end else begin
          if (vy_neg) begin
            ny = sat_pos(ny_up);
          end else begin
            ny  = sat_pos(ny_down);
            gnd = 1'b1;
          end
          nvy = '0;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      collided_o  <= hit_q;
      new_pos_x_o <= nx;
      new_pos_y_o <= ny;
      new_vel_x_o <= nvx;
      new_vel_y_o <= nvy;
      on_ground_o <= gnd;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o.clear_done = clr_done_q;
  assign status_o.hit        = pend_hit;
  assign status_o.done       = pend_valid_q && pend_last_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/core/tile_aabb_collision_resolver_core.sv =====
// A collide or resolve transaction, once accepted, runs a start state, a scan of its tiles,
// one per cycle, up to and including the first solid one, and a resolve state that loads
// the output register; a tile write runs a write state and then the resolve state. One
// transaction at a time: the next is accepted only once the last leaves the resolve state;
// a result waiting in the output register does not block the next acceptance, but the next
// finish stalls until it drains. Reset first sweeps the map to air, one entry per cycle.
module tile_aabb_collision_resolver_core import tacr_pkg::*; #(
  parameter int unsigned MAP_WIDTH  = MAP_WIDTH_DEF,
  parameter int unsigned MAP_HEIGHT = MAP_HEIGHT_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [WW_W-1:0]         cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              op_i,
  input  logic [TX_W-1:0]         tile_x_i,
  input  logic [TY_W-1:0]         tile_y_i,
  input  logic                    tile_solid_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] vel_x_i,
  input  logic signed [POS_W-1:0] vel_y_i,
  input  logic [HW_W-1:0]         half_width_i,
  input  logic [HT_W-1:0]         box_height_i,
  input  logic                    ground_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    collided_o,
  output logic signed [POS_W-1:0] new_pos_x_o,
  output logic signed [POS_W-1:0] new_pos_y_o,
  output logic signed [POS_W-1:0] new_vel_x_o,
  output logic signed [POS_W-1:0] new_vel_y_o,
  output logic                    on_ground_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tacr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_e'(op_i)),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  tacr_dp #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .op_i         (op_i),
    .tile_x_i     (tile_x_i),
    .tile_y_i     (tile_y_i),
    .tile_solid_i (tile_solid_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .vel_x_i      (vel_x_i),
    .vel_y_i      (vel_y_i),
    .half_width_i (half_width_i),
    .box_height_i (box_height_i),
    .ground_in_i  (ground_in_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .collided_o   (collided_o),
    .new_pos_x_o  (new_pos_x_o),
    .new_pos_y_o  (new_pos_y_o),
    .new_vel_x_o  (new_vel_x_o),
    .new_vel_y_o  (new_vel_y_o),
    .on_ground_o  (on_ground_o)
  );

endmodule
